>>> design/ifdd_pkg.sv
// ----------------------------------------------------------------------------
// ifdd_pkg - shared types and constants for the information frame deframer
// Result record, configuration bundle, register indexes and sizing.
// ----------------------------------------------------------------------------
package ifdd_pkg;

   localparam int MAX_PAYLOAD = 1024;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int LEN_W       = 11;

   localparam logic [7:0] ESC_BYTE = 8'h7D;
   localparam logic [7:0] XOR_MASK = 8'h20;

   // Result queue sizing
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PW    = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CW    = $clog2(RSPQ_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] REG_FLAG   = 3'd0;
   localparam logic [CSR_AW-1:0] REG_ADDR   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_CTRL0  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_CTRL1  = 3'd3;
   localparam logic [CSR_AW-1:0] REG_HCHK0  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_HCHK1  = 3'd5;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] address_byte;
      logic [7:0] control_seq0;
      logic [7:0] control_seq1;
      logic [7:0] header_check_seq0;
      logic [7:0] header_check_seq1;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic             ok;
      logic             seq;
      logic [LEN_W-1:0] len;
      logic             ovf;
      logic             last;
   } rslt_type;

   // Up to two results per received byte
   typedef struct packed {
      logic [1:0]     n;
      rslt_type [1:0] rs;
   } step_out_type;

   function automatic rslt_type mk_payload(logic [7:0] d);
      rslt_type r;
      r      = '0;
      r.data = d;
      return r;
   endfunction

endpackage

>>> design/ifdd_csr.sv
// ----------------------------------------------------------------------------
// ifdd_csr - configuration registers
// Six byte-wide registers written through a plain write port.
// ----------------------------------------------------------------------------
module ifdd_csr import ifdd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [7:0]        csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_FLAG:  cfg_in.flag_byte         = csr_wdata;
            REG_ADDR:  cfg_in.address_byte      = csr_wdata;
            REG_CTRL0: cfg_in.control_seq0      = csr_wdata;
            REG_CTRL1: cfg_in.control_seq1      = csr_wdata;
            REG_HCHK0: cfg_in.header_check_seq0 = csr_wdata;
            REG_HCHK1: cfg_in.header_check_seq1 = csr_wdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte         <= 8'h7E;
         cfg_ff.address_byte      <= 8'h03;
         cfg_ff.control_seq0      <= 8'h00;
         cfg_ff.control_seq1      <= 8'h40;
         cfg_ff.header_check_seq0 <= 8'h03;
         cfg_ff.header_check_seq1 <= 8'h43;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/ifdd_core.sv
// ----------------------------------------------------------------------------
// ifdd_core - header hunt, destuffing and check byte tracking
// Consumes one line byte per step and yields up to two results.
// ----------------------------------------------------------------------------
module ifdd_core import ifdd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         step_en,
   input  logic [7:0]   rx_byte,
   output step_out_type step_out
);

   typedef enum logic [2:0] {
      ST_START,
      ST_FLAG,
      ST_ADDR,
      ST_CTRL,
      ST_HDR,
      ST_DATA
   } hunt_type;

   typedef struct packed {
      logic [7:0]       xsum;
      logic [7:0]       held;
      logic             held_vld;
      logic [CNT_W-1:0] cnt;
      logic             ovf;
   } pay_type;

   typedef struct packed {
      pay_type    st;
      logic       emit;
      logic [7:0] data;
   } push_res_type;

   // One destuffed byte enters the hold slot; the previous one goes out
   function automatic push_res_type push_byte(pay_type p, logic [7:0] d);
      push_res_type r;
      r.st   = p;
      r.emit = p.held_vld;
      r.data = p.held;
      if (p.held_vld) begin
         r.st.xsum = p.xsum ^ p.held;
         if (p.cnt >= CNT_W'(MAX_PAYLOAD)) begin
            r.st.cnt = CNT_W'(MAX_PAYLOAD);
            r.st.ovf = 1'b1;
         end else begin
            r.st.cnt = p.cnt + CNT_W'(1);
         end
      end
      r.st.held     = d;
      r.st.held_vld = 1'b1;
      return r;
   endfunction

   hunt_type     hunt_ff, hunt_in;
   logic         seq_ff, seq_in;
   logic         esc_ff, esc_in;
   pay_type      pay_ff, pay_in;

   logic         p0_en, p1_en, vrd_en;
   logic [7:0]   p0_d, p1_d;
   push_res_type pr0, pr1;
   pay_type      pay_a, pay_b;
   logic [1:0]   n;
   rslt_type [1:0] rs;
   rslt_type     vrd;
   logic         is_flag;

   assign is_flag = (rx_byte == cfg.flag_byte);

   always_comb begin
      hunt_in = hunt_ff;
      seq_in  = seq_ff;
      esc_in  = esc_ff;
      p0_en   = 1'b0;
      p1_en   = 1'b0;
      vrd_en  = 1'b0;
      p0_d    = rx_byte;
      p1_d    = rx_byte;
      pay_a   = pay_ff;

      unique case (hunt_ff)
         ST_START: begin
            if (is_flag) hunt_in = ST_FLAG;
         end
         ST_FLAG: begin
            if (is_flag)                           hunt_in = ST_FLAG;
            else if (rx_byte == cfg.address_byte)  hunt_in = ST_ADDR;
            else                                   hunt_in = ST_START;
         end
         ST_ADDR: begin
            if (is_flag) begin
               hunt_in = ST_FLAG;
            end else if (rx_byte == cfg.control_seq0 || rx_byte == cfg.control_seq1) begin
               seq_in  = (rx_byte != cfg.control_seq0);
               hunt_in = ST_CTRL;
            end else begin
               hunt_in = ST_START;
            end
         end
         ST_CTRL: begin
            // header check test ranks above the flag test here
            if (rx_byte == cfg.header_check_seq0 || rx_byte == cfg.header_check_seq1) begin
               hunt_in = ST_HDR;
               esc_in  = 1'b0;
               pay_a   = '0;
            end else if (is_flag) begin
               hunt_in = ST_FLAG;
            end else begin
               hunt_in = ST_START;
            end
         end
         ST_HDR, ST_DATA: begin
            if (is_flag) begin
               if (hunt_ff == ST_HDR) begin
                  hunt_in = ST_FLAG;
               end else begin
                  // dangling escape is pushed as a plain escape byte and becomes the check byte
                  p0_en   = esc_ff;
                  p0_d    = ESC_BYTE;
                  esc_in  = 1'b0;
                  vrd_en  = 1'b1;
                  hunt_in = ST_START;
               end
            end else begin
               hunt_in = ST_DATA;
               if (esc_ff) begin
                  esc_in = 1'b0;
                  p0_en  = 1'b1;
                  if (rx_byte == (cfg.flag_byte ^ XOR_MASK)) begin
                     p0_d = cfg.flag_byte;
                  end else if (rx_byte == (ESC_BYTE ^ XOR_MASK)) begin
                     p0_d = ESC_BYTE;
                  end else begin
                     // unknown escape pair passes through as two bytes
                     p0_d  = ESC_BYTE;
                     p1_en = 1'b1;
                     p1_d  = rx_byte;
                  end
               end else if (rx_byte == ESC_BYTE) begin
                  esc_in = 1'b1;
               end else begin
                  p0_en = 1'b1;
               end
            end
         end
         default: hunt_in = ST_START;
      endcase

      pr0    = push_byte(pay_a, p0_d);
      pay_b  = p0_en ? pr0.st : pay_a;
      pr1    = push_byte(pay_b, p1_d);
      pay_in = p1_en ? pr1.st : pay_b;

      vrd      = '0;
      vrd.kind = 1'b1;
      vrd.ok   = pay_in.held_vld && (pay_in.xsum == pay_in.held) && !pay_in.ovf;
      vrd.seq  = seq_in;
      vrd.len  = LEN_W'(pay_in.cnt);
      vrd.ovf  = pay_in.ovf;

      n  = 2'd0;
      rs = '0;
      if (p0_en && pr0.emit) begin
         rs[n[0]] = mk_payload(pr0.data);
         n        = n + 2'd1;
      end
      if (p1_en && pr1.emit) begin
         rs[n[0]] = mk_payload(pr1.data);
         n        = n + 2'd1;
      end
      if (vrd_en) begin
         rs[n[0]] = vrd;
         n        = n + 2'd1;
      end
      if (n != 2'd0) rs[n[1]].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff <= ST_START;
         seq_ff  <= 1'b0;
         esc_ff  <= 1'b0;
         pay_ff  <= '0;
      end else if (step_en) begin
         hunt_ff <= hunt_in;
         seq_ff  <= seq_in;
         esc_ff  <= esc_in;
         pay_ff  <= pay_in;
      end
   end

   assign step_out.n  = n;
   assign step_out.rs = rs;

   a_esc_in_data: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> hunt_ff == ST_DATA)
      else $error("escape pending outside payload");

   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      pay_ff.cnt <= CNT_W'(MAX_PAYLOAD))
      else $error("payload count beyond saturation");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      n == 2'd2 |-> !rs[0].kind && !rs[0].last && rs[1].last)
      else $error("verdict not the final result of a byte");

endmodule

>>> design/ifdd_resq.sv
// ----------------------------------------------------------------------------
// ifdd_resq - result queue
// Takes up to two results per cycle, hands out one beat per cycle while pop is held.
// ----------------------------------------------------------------------------
module ifdd_resq import ifdd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_en,
   input  step_out_type step_out,
   output logic         room2,
   output logic         head_vld,
   output rslt_type     head,
   input  logic         pop
);

   rslt_type             mem_ff [RSPQ_DEPTH];
   logic [RSPQ_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CW-1:0]   cnt_ff, cnt_in;
   logic [1:0]           push_n;
   logic                 pop_ok;

   assign push_n    = push_en ? step_out.n : 2'd0;
   assign pop_ok    = pop && head_vld;
   assign wr_ptr_in = wr_ptr_ff + RSPQ_PW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + RSPQ_PW'(pop_ok);
   assign cnt_in    = cnt_ff + RSPQ_CW'(push_n) - RSPQ_CW'(pop_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ptr_ff] <= step_out.rs[0];
      if (push_n == 2'd2) mem_ff[wr_ptr_ff + RSPQ_PW'(1)] <= step_out.rs[1];
   end

   assign room2    = (cnt_ff <= RSPQ_CW'(RSPQ_DEPTH - 2));
   assign head_vld = (cnt_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> cnt_ff <= RSPQ_CW'(RSPQ_DEPTH - 2))
      else $error("result queue written without room");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      RSPQ_PW'(cnt_ff) == RSPQ_PW'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue fill disagrees with pointers");

endmodule

>>> design/info_frame_deframer_destuffer_top.sv
// ----------------------------------------------------------------------------
// info_frame_deframer_destuffer_top - byte-stuffed information frame receiver
// Hunts for the frame header, destuffs payload and gives an end-of-frame verdict.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   req_rx_byte
//  rsp_      out        rsp_valid/rsp_ready   payload byte or verdict, rsp_last_of_run
//  csr_      in         csr_wr_en             csr_index, csr_wdata
//
// One line byte per cycle while the result queue has room; a req beat passes
// through the input register and then the result queue before rsp_valid rises.
// A byte yielding two results is handed out as two beats through the
// single-beat result port.
// The input register stalls while the four-entry result queue has under two
// free slots. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module info_frame_deframer_destuffer_top import ifdd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_result_kind,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_frame_ok,
   output logic              rsp_seq_num,
   output logic [LEN_W-1:0]  rsp_payload_len,
   output logic              rsp_overflow,
   output logic              rsp_last_of_run,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [7:0]        csr_wdata
);

   cfg_type      cfg;
   step_out_type step_out;
   rslt_type     head;
   logic         in_vld_ff, in_vld_in;
   logic [7:0]   in_byte_ff;
   logic         room2;
   logic         advance;

   assign advance   = in_vld_ff && room2;
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) in_vld_in = 1'b1;
      else if (advance)           in_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
   end

   ifdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ifdd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step_en  (advance),
      .rx_byte  (in_byte_ff),
      .step_out (step_out)
   );

   ifdd_resq u_resq (
      .clock    (clock),
      .reset    (reset),
      .push_en  (advance),
      .step_out (step_out),
      .room2    (room2),
      .head_vld (rsp_valid),
      .head     (head),
      .pop      (rsp_ready)
   );

   assign rsp_result_kind = head.kind;
   assign rsp_data_byte   = head.data;
   assign rsp_frame_ok    = head.ok;
   assign rsp_seq_num     = head.seq;
   assign rsp_payload_len = head.len;
   assign rsp_overflow    = head.ovf;
   assign rsp_last_of_run = head.last;

endmodule
